>>> rtl/bam_pkg.sv
// Shared definitions for the byte ALU: opcode encodings and the
// result bundle passed from the ALU datapath to the top level.
// No dependencies.
package bam_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned OpW   = 8;

  localparam logic [OpW-1:0] OPC_ADD   = 8'h00;
  localparam logic [OpW-1:0] OPC_SUB   = 8'h01;
  localparam logic [OpW-1:0] OPC_NEG   = 8'h02;
  localparam logic [OpW-1:0] OPC_EQ    = 8'h03;
  localparam logic [OpW-1:0] OPC_LT    = 8'h04;
  localparam logic [OpW-1:0] OPC_GT    = 8'h05;
  localparam logic [OpW-1:0] OPC_AND   = 8'h06;
  localparam logic [OpW-1:0] OPC_OR    = 8'h07;
  localparam logic [OpW-1:0] OPC_SLL   = 8'h08;
  localparam logic [OpW-1:0] OPC_SRL   = 8'h09;
  localparam logic [OpW-1:0] OPC_MULTU = 8'h0A;
  localparam logic [OpW-1:0] OPC_MULT  = 8'h0B;
  localparam logic [OpW-1:0] OPC_ADDU  = 8'h10;
  localparam logic [OpW-1:0] OPC_SUBU  = 8'h11;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             overflow;
    logic             known;
  } alu_res_t;

endpackage

>>> rtl/bam_alu.sv
// Combinational datapath of the byte ALU: decodes the opcode and
// computes the result byte and signed-overflow flag for one operation.
// Depends on bam_pkg.
module bam_alu
  import bam_pkg::*;
(
  input  logic [OpW-1:0]   op,
  input  logic [DataW-1:0] operand_a,
  input  logic [DataW-1:0] operand_b,
  input  logic [DataW-1:0] last_result,
  output alu_res_t         res
);

  // The signed multiply flags overflow of any shift-and-add partial sum,
  // taken from the lowest set bit of b upward.
  function automatic logic mult_ovf(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic [DataW-1:0] acc;
    logic [DataW-1:0] part;
    logic [DataW-1:0] sum;
    logic             ovf;
    acc = '0;
    ovf = 1'b0;
    for (int i = 0; i < DataW; i++) begin
      if (b[i]) begin
        part = a << i;
        sum  = acc + part;
        ovf  = ovf | ((acc[DataW-1] ^ sum[DataW-1]) & (part[DataW-1] ^ sum[DataW-1]));
        acc  = sum;
      end
    end
    return ovf;
  endfunction

  logic [DataW-1:0]   sum;
  logic [DataW-1:0]   diff;
  logic [2*DataW-1:0] prod;
  logic               add_ovf;
  logic               sub_ovf;
  logic               lt;
  logic               gt;

  assign sum  = operand_a + operand_b;
  assign diff = operand_a - operand_b;
  assign prod = operand_a * operand_b;

  assign add_ovf = (operand_a[DataW-1] ^ sum[DataW-1]) & (operand_b[DataW-1] ^ sum[DataW-1]);
  assign sub_ovf = (operand_a[DataW-1] ^ operand_b[DataW-1]) &
                   (operand_a[DataW-1] ^ diff[DataW-1]);
  assign lt = $signed(operand_a) < $signed(operand_b);
  assign gt = $signed(operand_a) > $signed(operand_b);

  always_comb begin
    res.result   = '0;
    res.overflow = 1'b0;
    res.known    = 1'b1;
    case (op)
      OPC_ADD: begin
        res.result   = sum;
        res.overflow = add_ovf;
      end
      OPC_SUB: begin
        res.result   = diff;
        res.overflow = sub_ovf;
      end
      OPC_NEG:   res.result = DataW'(0) - operand_a;
      OPC_EQ:    res.result = DataW'(operand_a == operand_b);
      OPC_LT:    res.result = DataW'(lt);
      OPC_GT:    res.result = DataW'(gt);
      OPC_AND:   res.result = operand_a & operand_b;
      OPC_OR:    res.result = operand_a | operand_b;
      OPC_SLL:   res.result = {operand_a[DataW-2:0], 1'b0};
      OPC_SRL:   res.result = {1'b0, operand_a[DataW-1:1]};
      OPC_MULTU: res.result = prod[DataW-1:0];
      OPC_MULT: begin
        res.result   = prod[DataW-1:0];
        res.overflow = mult_ovf(operand_a, operand_b);
      end
      OPC_ADDU:  res.result = sum;
      OPC_SUBU:  res.result = diff;
      default: begin
        res.result = last_result;
        res.known  = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/byte_alu_with_multiply.sv
// Top level of the byte ALU: input register, ALU datapath, result register
// and the remembered last result. Depends on bam_pkg and bam_alu.
//
// The block takes one operation per clock cycle while in_stall is low and
// passes each through the input register, a single pass through the ALU
// datapath and the result register, in that order. An unknown opcode
// returns the result of the last known opcode ahead of it (zero after
// reset) with the overflow flag clear. A stall on the result side holds
// the result register and, once the input register is also full, stalls
// the input side in the same cycle.
module byte_alu_with_multiply
  import bam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OpW-1:0]   in_op,
  input  logic [DataW-1:0] in_operand_a,
  input  logic [DataW-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] out_result,
  output logic             out_overflow
);

  logic             in_vld_r;
  logic [OpW-1:0]   op_r;
  logic [DataW-1:0] a_r;
  logic [DataW-1:0] b_r;
  logic             out_vld_r;
  logic [DataW-1:0] result_r;
  logic             overflow_r;
  logic [DataW-1:0] last_r;
  logic [DataW-1:0] last_nxt;
  logic             adv_out;
  logic             adv_in;
  alu_res_t         alu_res;

  bam_alu u_alu (
    .op          (op_r),
    .operand_a   (a_r),
    .operand_b   (b_r),
    .last_result (last_r),
    .res         (alu_res)
  );

  assign adv_out  = !out_vld_r || !out_stall;
  assign adv_in   = !in_vld_r || adv_out;
  assign in_stall = !adv_in;

  assign last_nxt = (in_vld_r && adv_out && alu_res.known) ? alu_res.result : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      last_r    <= '0;
    end else begin
      if (adv_in) begin
        in_vld_r <= in_valid;
      end
      if (adv_out) begin
        out_vld_r <= in_vld_r;
      end
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      op_r <= in_op;
      a_r  <= in_operand_a;
      b_r  <= in_operand_b;
    end
    if (adv_out && in_vld_r) begin
      result_r   <= alu_res.result;
      overflow_r <= alu_res.overflow;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_result   = result_r;
  assign out_overflow = overflow_r;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for byte_alu_with_multiply: a directed table, then random
// operations, random input gaps and result stalls, and one long result hold-off.
// Depends on bam_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bam_pkg::*;

  // Opcodes that the block does not decode.
  localparam logic [OpW-1:0] UNDEF_OP_TOP = 8'hFF;
  localparam logic [OpW-1:0] UNDEF_OP_GAP = 8'h0C;
  localparam logic [OpW-1:0] UNDEF_OP_MSB = 8'h80;

  localparam int RANDOM_OPS    = 1630;
  localparam int QUIET_TAIL    = 200;
  localparam int HOLD_AT_BEAT  = 500;
  localparam int HOLD_CYCLES   = 40;
  localparam int IDLE_LIMIT    = 1000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int DIRECTED_ROWS = 23;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic             typed;     // expected values below are given by hand
    logic [DataW-1:0] res;
    logic             ovf;
  } alu_op_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             ovf;
  } alu_out_t;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [OpW-1:0]   in_op        = '0;
  logic [DataW-1:0] in_operand_a = '0;
  logic [DataW-1:0] in_operand_b = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [DataW-1:0] out_result;
  logic             out_overflow;

  byte_alu_with_multiply uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result),
    .out_overflow (out_overflow)
  );

  alu_op_t  op_list[$];
  alu_out_t expected_results[$];
  logic [DataW-1:0] last_known_result;
  alu_op_t  cur_op;
  alu_out_t cur_out;
  alu_out_t exp_out;
  int  feed_idx, gap_left, stall_left, idle_cycles;
  int  beats_in, results_checked, mismatches, undef_ops, overflows;
  logic next_valid, next_stall, hold_off = 1'b0;

  alu_op_t directed_tbl [DIRECTED_ROWS] = '{
    '{UNDEF_OP_TOP, 8'h12, 8'h34, 1'b1, 8'h00, 1'b0},
    '{OPC_ADD,      8'h7F, 8'h01, 1'b1, 8'h80, 1'b1},
    '{OPC_ADD,      8'hFF, 8'hFF, 1'b1, 8'hFE, 1'b0},
    '{OPC_ADD,      8'h80, 8'h80, 1'b1, 8'h00, 1'b1},
    '{OPC_SUB,      8'h00, 8'h80, 1'b1, 8'h80, 1'b1},
    '{OPC_SUB,      8'h80, 8'h01, 1'b1, 8'h7F, 1'b1},
    '{OPC_NEG,      8'h80, 8'hFF, 1'b1, 8'h80, 1'b0},
    '{OPC_NEG,      8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
    '{OPC_EQ,       8'hA5, 8'hA5, 1'b1, 8'h01, 1'b0},
    '{OPC_LT,       8'h80, 8'h7F, 1'b1, 8'h01, 1'b0},
    '{OPC_GT,       8'h80, 8'h7F, 1'b1, 8'h00, 1'b0},
    '{OPC_AND,      8'hFF, 8'h5A, 1'b1, 8'h5A, 1'b0},
    '{OPC_OR,       8'h00, 8'hA5, 1'b1, 8'hA5, 1'b0},
    '{OPC_SLL,      8'hFF, 8'h00, 1'b1, 8'hFE, 1'b0},
    '{OPC_SRL,      8'hFF, 8'hFF, 1'b1, 8'h7F, 1'b0},
    '{OPC_MULTU,    8'hFF, 8'hFF, 1'b1, 8'h01, 1'b0},
    '{OPC_MULT,     8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0},
    '{OPC_MULT,     8'h7F, 8'h03, 1'b0, 8'h00, 1'b0},
    '{OPC_MULT,     8'h00, 8'h00, 1'b1, 8'h00, 1'b0},
    '{OPC_ADDU,     8'h7F, 8'h01, 1'b1, 8'h80, 1'b0},
    '{OPC_SUBU,     8'h00, 8'h01, 1'b1, 8'hFF, 1'b0},
    '{UNDEF_OP_GAP, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0},
    '{UNDEF_OP_MSB, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  logic [OpW-1:0] known_ops [14] = '{
    OPC_ADD, OPC_SUB, OPC_NEG, OPC_EQ, OPC_LT, OPC_GT, OPC_AND,
    OPC_OR, OPC_SLL, OPC_SRL, OPC_MULTU, OPC_MULT, OPC_ADDU, OPC_SUBU
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out one result and advances the remembered last result.
  function automatic alu_out_t alu_compute(logic [OpW-1:0] op, logic [DataW-1:0] a,
                                           logic [DataW-1:0] b);
    alu_out_t r;
    logic [DataW-1:0] part, sum;
    logic known;
    int i;
    r = '0;
    known = 1'b1;
    case (op)
      OPC_ADD: begin
        r.res = a + b;
        r.ovf = (a[7] == b[7]) && (r.res[7] != a[7]);
      end
      OPC_SUB: begin
        r.res = a - b;
        r.ovf = (a[7] != b[7]) && (r.res[7] != a[7]);
      end
      OPC_NEG:   r.res = -a;
      OPC_EQ:    r.res = DataW'(a == b);
      OPC_LT:    r.res = DataW'($signed(a) < $signed(b));
      OPC_GT:    r.res = DataW'($signed(a) > $signed(b));
      OPC_AND:   r.res = a & b;
      OPC_OR:    r.res = a | b;
      OPC_SLL:   r.res = {a[6:0], 1'b0};
      OPC_SRL:   r.res = {1'b0, a[7:1]};
      OPC_MULTU: r.res = a * b;
      OPC_MULT: begin
        // Shift-and-add; any signed overflow of a partial sum sets the flag.
        for (i = 0; i < DataW; i++) begin
          if (b[i]) begin
            part = a << i;
            sum = r.res + part;
            if (r.res[7] == part[7] && sum[7] != r.res[7]) r.ovf = 1'b1;
            r.res = sum;
          end
        end
      end
      OPC_ADDU:  r.res = a + b;
      OPC_SUBU:  r.res = a - b;
      default: begin
        known = 1'b0;
        r.res = last_known_result;
      end
    endcase
    if (known) last_known_result = r.res;
    else undef_ops++;
    if (r.ovf) overflows++;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
    return DataW'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Sender: walks the operation list, with idle bursts except in the tail.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      cur_out = alu_compute(in_op, in_operand_a, in_operand_b);
      if (cur_op.typed) begin
        cur_out.res = cur_op.res;
        cur_out.ovf = cur_op.ovf;
      end
      expected_results.push_back(cur_out);
      beats_in++;
    end
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_valid || !in_stall) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (feed_idx + QUIET_TAIL < op_list.size() && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 4);
      end else if (feed_idx < op_list.size()) begin
        cur_op = op_list[feed_idx];
        feed_idx++;
        in_op <= cur_op.op;
        in_operand_a <= cur_op.a;
        in_operand_b <= cur_op.b;
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: random stall bursts, plus the long hold-off when requested.
  always @(posedge clk) begin
    next_stall = 1'b0;
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (feed_idx + QUIET_TAIL < op_list.size() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        next_stall = 1'b1;
      end
    end
    out_stall <= next_stall || hold_off;
  end

  // Hold the result side for a long stretch so the input side backs up.
  initial begin
    wait (beats_in >= HOLD_AT_BEAT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Result checker: every accepted beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result beat", int'(out_result), 0);
      end else begin
        exp_out = expected_results.pop_front();
        if (out_result !== exp_out.res)
          flag_mismatch("result", int'(out_result), int'(exp_out.res));
        if (out_overflow !== exp_out.ovf)
          flag_mismatch("overflow", int'(out_overflow), int'(exp_out.ovf));
        results_checked++;
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    alu_op_t item;
    last_known_result = '0;
    for (int r = 0; r < DIRECTED_ROWS; r++) op_list.push_back(directed_tbl[r]);
    for (int n = 0; n < RANDOM_OPS; n++) begin
      item = '0;
      if ($urandom_range(0, 3) == 0) item.op = OpW'($urandom_range(0, 255));
      else item.op = known_ops[$urandom_range(0, 13)];
      item.a = pick_operand();
      item.b = pick_operand();
      op_list.push_back(item);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (beats_in < op_list.size() || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d operations, %0d with undecoded opcodes and %0d with overflow set;",
             beats_in, undef_ops, overflows);
    $display("%0d results checked, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
